@@ rtl/assert_macros.svh @@
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled in reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define SHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shdrv_pkg.sv @@
//------------------------------------------------------------------------------
// Half-step driver package
// Opcodes, register indexes, reset values and the half-step coil pattern.
//------------------------------------------------------------------------------
`default_nettype none

package shdrv_pkg;

  localparam int unsigned STEP_COUNT_BITS_DEF = 16;
  localparam int unsigned POSITION_BITS_DEF   = 16;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned COILS_W   = 4;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FIELD_W-1:0] STEP_PERIOD_RST = 16'd800;
  localparam logic [FIELD_W-1:0] POS_MODULUS_RST = 16'd4096;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_ZERO    = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD = 1'd0,
    CFG_POS_MODULUS = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic step_taken;
    logic step_fwd;
  } step_flags_t;

  typedef struct packed {
    logic [COILS_W-1:0] coils;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] steps_left;
    logic               idle;
    logic               stepped;
  } result_t;

  function automatic logic [COILS_W-1:0] half_step_coils(input logic [PHASE_W-1:0] phase);
    logic [COILS_W-1:0] pattern;
    unique case (phase)
      3'd0:    pattern = 4'h1;
      3'd1:    pattern = 4'h3;
      3'd2:    pattern = 4'h2;
      3'd3:    pattern = 4'h6;
      3'd4:    pattern = 4'h4;
      3'd5:    pattern = 4'hC;
      3'd6:    pattern = 4'h8;
      default: pattern = 4'h9;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

@@ rtl/shdrv_cmd_if.sv @@
//------------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface shdrv_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] step_count;

  modport source (output valid, output opcode, output step_count, input ready);
  modport sink   (input valid, input opcode, input step_count, output ready);
endinterface

`default_nettype wire

@@ rtl/shdrv_res_if.sv @@
//------------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface shdrv_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic [15:0] position;
  logic [15:0] steps_left;
  logic        idle;
  logic        stepped;

  modport source (output valid, output coils, output position, output steps_left,
                  output idle, output stepped, input ready);
  modport sink   (input valid, input coils, input position, input steps_left,
                  input idle, input stepped, output ready);
endinterface

`default_nettype wire

@@ rtl/shdrv_step_unit.sv @@
//------------------------------------------------------------------------------
// Half-step update unit
// Next-state logic for one command: tick timing, stepping, position wrap, load, cancel, release and zero.
//------------------------------------------------------------------------------
`default_nettype none

module shdrv_step_unit
  import shdrv_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = STEP_COUNT_BITS_DEF,
  parameter int unsigned POSITION_BITS   = POSITION_BITS_DEF
) (
  input  wire logic [OPCODE_W-1:0]        opcode_i,
  input  wire logic signed [FIELD_W-1:0]  step_count_i,
  input  wire logic [FIELD_W-1:0]         period_i,
  input  wire logic [FIELD_W-1:0]         modulus_i,
  input  wire logic [PHASE_W-1:0]         phase_i,
  input  wire logic [COILS_W-1:0]         coils_i,
  input  wire logic [POSITION_BITS-1:0]   pos_i,
  input  wire logic signed [STEP_COUNT_BITS-1:0] rem_i,
  input  wire logic [FIELD_W-1:0]         ticks_i,
  output logic [PHASE_W-1:0]              phase_o,
  output logic [COILS_W-1:0]              coils_o,
  output logic [POSITION_BITS-1:0]        pos_o,
  output logic signed [STEP_COUNT_BITS-1:0] rem_o,
  output logic [FIELD_W-1:0]              ticks_o,
  output step_flags_t                     flags_o
);

  localparam int unsigned CW = (STEP_COUNT_BITS > FIELD_W) ? STEP_COUNT_BITS : FIELD_W;
  localparam int unsigned PW = ((POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W) + 1;
  localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (STEP_COUNT_BITS - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

  logic [FIELD_W-1:0]        ticks_inc;
  logic                      step_now;
  logic                      fwd;
  logic [PW-1:0]             pos_ext;
  logic [PW-1:0]             pos_inc;
  logic [PW-1:0]             mod_ext;
  logic [PW-1:0]             pos_step;
  logic signed [CW-1:0]      count_ext;
  logic signed [CW-1:0]      count_sat;
  logic [PHASE_W-1:0]        phase_step;

  always_comb begin
    ticks_inc = (ticks_i < period_i) ? ticks_i + FIELD_W'(1) : ticks_i;
    step_now  = (rem_i != '0) && (ticks_inc >= period_i);
    fwd       = (rem_i > 0);

    pos_ext = PW'(pos_i);
    pos_inc = pos_ext + PW'(1);
    mod_ext = (modulus_i == '0) ? PW'(1) : PW'(modulus_i);
    if (fwd) begin
      pos_step = (pos_inc >= mod_ext) ? '0 : pos_inc;
    end else begin
      pos_step = ((pos_ext == '0) || (pos_ext > mod_ext)) ? mod_ext - PW'(1)
                                                          : pos_ext - PW'(1);
    end
    phase_step = fwd ? phase_i + PHASE_W'(1) : phase_i - PHASE_W'(1);

    count_ext = CW'(step_count_i);
    if (count_ext > SAT_HI) begin
      count_sat = SAT_HI;
    end else if (count_ext < SAT_LO) begin
      count_sat = SAT_LO;
    end else begin
      count_sat = count_ext;
    end

    phase_o = phase_i;
    coils_o = coils_i;
    pos_o   = pos_i;
    rem_o   = rem_i;
    ticks_o = ticks_i;
    flags_o = '0;

    unique case (opcode_e'(opcode_i))
      OP_TICK: begin
        ticks_o = ticks_inc;
        if (step_now) begin
          phase_o = phase_step;
          coils_o = half_step_coils(phase_step);
          pos_o   = pos_step[POSITION_BITS-1:0];
          rem_o   = fwd ? rem_i - STEP_COUNT_BITS'(1) : rem_i + STEP_COUNT_BITS'(1);
          ticks_o = '0;
          flags_o.step_taken = 1'b1;
          flags_o.step_fwd   = fwd;
        end
      end
      OP_LOAD: begin
        rem_o = count_sat[STEP_COUNT_BITS-1:0];
      end
      OP_CANCEL: begin
        rem_o = '0;
      end
      OP_RELEASE: begin
        coils_o = '0;
      end
      OP_ZERO: begin
        pos_o = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stepper_half_step_driver_core.sv @@
//------------------------------------------------------------------------------
// Stepper half-step driver core
// Four-coil half-step sequencer with step timing and wrapping position count.
//------------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction, in the cycle
// after acceptance. The state is updated in the cycle a command is accepted and
// the result is held in an output register, so one command is taken every clock
// cycle while the result side keeps up; a stalled result holds off only the next
// command. Tick commands are timed in microseconds by the caller. Configuration
// writes are meant for idle periods and take effect from the next command.
`default_nettype none

module stepper_half_step_driver_core
  import shdrv_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = STEP_COUNT_BITS_DEF,
  parameter int unsigned POSITION_BITS   = POSITION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FIELD_W-1:0]   cfg_data_i,
  shdrv_cmd_if.sink                 cmd_i,
  shdrv_res_if.source               res_o
);

  `include "assert_macros.svh"

  localparam int unsigned CW = (STEP_COUNT_BITS > FIELD_W) ? STEP_COUNT_BITS : FIELD_W;
  localparam int unsigned PW = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;

  logic [FIELD_W-1:0]                 period_q;
  logic [FIELD_W-1:0]                 modulus_q;
  logic [PHASE_W-1:0]                 phase_q, phase_d;
  logic [COILS_W-1:0]                 coils_q, coils_d;
  logic [POSITION_BITS-1:0]           pos_q, pos_d;
  logic signed [STEP_COUNT_BITS-1:0]  rem_q, rem_d;
  logic [FIELD_W-1:0]                 ticks_q, ticks_d;
  step_flags_t                        flags;
  logic                               out_valid_q;
  result_t                            res_q, res_d;
  logic                               cmd_acc;
  logic signed [CW-1:0]               rem_ext;
  logic [PW-1:0]                      pos_ext;
  logic                               step_acc;
  logic                               res_stepped;
  logic [PHASE_W-1:0]                 phase_exp;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  shdrv_step_unit #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS),
    .POSITION_BITS   (POSITION_BITS)
  ) u_step (
    .opcode_i     (cmd_i.opcode),
    .step_count_i (cmd_i.step_count),
    .period_i     (period_q),
    .modulus_i    (modulus_q),
    .phase_i      (phase_q),
    .coils_i      (coils_q),
    .pos_i        (pos_q),
    .rem_i        (rem_q),
    .ticks_i      (ticks_q),
    .phase_o      (phase_d),
    .coils_o      (coils_d),
    .pos_o        (pos_d),
    .rem_o        (rem_d),
    .ticks_o      (ticks_d),
    .flags_o      (flags)
  );

  always_comb begin
    rem_ext          = CW'(rem_d);
    pos_ext          = PW'(pos_d);
    res_d.coils      = coils_d;
    res_d.position   = pos_ext[FIELD_W-1:0];
    res_d.steps_left = rem_ext[FIELD_W-1:0];
    res_d.idle       = (rem_d == '0);
    res_d.stepped    = flags.step_taken;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= STEP_PERIOD_RST;
      modulus_q <= POS_MODULUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_PERIOD: period_q  <= cfg_data_i;
        CFG_POS_MODULUS: modulus_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      coils_q <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
      ticks_q <= '0;
    end else if (cmd_acc) begin
      phase_q <= phase_d;
      coils_q <= coils_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      out_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.coils      = res_q.coils;
  assign res_o.position   = res_q.position;
  assign res_o.steps_left = res_q.steps_left;
  assign res_o.idle       = res_q.idle;
  assign res_o.stepped    = res_q.stepped;

  assign step_acc    = cmd_acc && flags.step_taken;
  assign res_stepped = out_valid_q && res_q.stepped;
  assign phase_exp   = flags.step_fwd ? phase_q + PHASE_W'(1) : phase_q - PHASE_W'(1);

  `SHD_ASSERT_NEXT(a_no_step_when_done, cmd_acc && rem_q == '0, !res_q.stepped, "step while idle")
  `SHD_ASSERT_NEXT(a_phase_moves_by_one, step_acc, phase_q == $past(phase_exp), "phase jump")
  `SHD_ASSERT_NOW(a_stepped_drives_coils, res_stepped, res_q.coils != '0, "coils off")
  `SHD_ASSERT_NEXT(a_step_clears_ticks, step_acc, ticks_q == '0, "ticks not cleared")

endmodule

`default_nettype wire

@@ dv/tb_stepper_half_step_driver_core.sv @@
//------------------------------------------------------------------------------
// Half-step driver core testbench
// Sends command transactions through the valid/ready channels with random
// gaps and result stalls. A predictor of the sequencer is kept in step with
// the block, and every result transaction is compared with it field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stepper_half_step_driver_core;
  import shdrv_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI  = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ROUNDS  = 6;
  localparam int unsigned ROUND_ITEMS    = 225;

  localparam logic [COILS_W-1:0] COIL_SEQUENCE [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [FIELD_W-1:0] cfg_data_i;

  shdrv_cmd_if cmd_if ();
  shdrv_res_if res_if ();

  stepper_half_step_driver_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [FIELD_W-1:0] cur_period;
  logic [FIELD_W-1:0] cur_modulus;
  logic [PHASE_W-1:0] drv_phase;
  logic [COILS_W-1:0] drv_coils;
  logic [FIELD_W-1:0] drv_position;
  logic signed [FIELD_W-1:0] drv_steps_left;
  logic [FIELD_W-1:0] drv_ticks;

  result_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic result_t advance_sequencer(input logic [OPCODE_W-1:0] op,
                                                input logic [FIELD_W-1:0] count);
    result_t r;
    logic took_step;
    logic [FIELD_W:0] wrap;
    took_step = 1'b0;
    wrap = (cur_modulus == '0) ? 17'd1 : {1'b0, cur_modulus};
    case (op)
      OP_TICK: begin
        if (drv_ticks < cur_period) drv_ticks = drv_ticks + 1'b1;
        if (drv_steps_left != 0 && drv_ticks >= cur_period) begin
          took_step = 1'b1;
          if (drv_steps_left > 0) begin
            drv_phase = drv_phase + 1'b1;
            drv_steps_left = drv_steps_left - FIELD_W'(1);
            if ({1'b0, drv_position} + 17'd1 >= wrap) drv_position = '0;
            else drv_position = drv_position + 1'b1;
          end else begin
            drv_phase = drv_phase - 1'b1;
            drv_steps_left = drv_steps_left + FIELD_W'(1);
            if (drv_position == '0 || {1'b0, drv_position} > wrap) begin
              drv_position = FIELD_W'(wrap - 17'd1);
            end else begin
              drv_position = drv_position - 1'b1;
            end
          end
          drv_coils = COIL_SEQUENCE[drv_phase];
          drv_ticks = '0;
        end
      end
      OP_LOAD:    drv_steps_left = count;
      OP_CANCEL:  drv_steps_left = '0;
      OP_RELEASE: drv_coils = '0;
      OP_ZERO:    drv_position = '0;
      default: ;
    endcase
    r.coils      = drv_coils;
    r.position   = drv_position;
    r.steps_left = drv_steps_left;
    r.idle       = (drv_steps_left == 0);
    r.stepped    = took_step;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] count);
    int unsigned gap;
    result_t predicted;
    gap = draw_gap();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= op;
    cmd_if.step_count <= count;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = advance_sequencer(op, count);
    pending_results.push_back(predicted);
  endtask

  task automatic wait_results_done();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] period,
                            input logic [FIELD_W-1:0] modulus);
    wait_results_done();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STEP_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cur_period = period;
    cfg_idx_i  <= CFG_POS_MODULUS;
    cfg_data_i <= modulus;
    @(posedge clk_i);
    cur_modulus = modulus;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] expv,
                             input logic [FIELD_W-1:0] actv);
    if (actv !== expv) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
    end
  endtask

  initial begin
    result_t want;
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          want = pending_results.pop_front();
          check_field("coils", FIELD_W'(want.coils), FIELD_W'(res_if.coils));
          check_field("position", want.position, res_if.position);
          check_field("steps_left", want.steps_left, res_if.steps_left);
          check_field("idle", FIELD_W'(want.idle), FIELD_W'(res_if.idle));
          check_field("stepped", FIELD_W'(want.stepped), FIELD_W'(res_if.stepped));
        end
        stall = draw_gap();
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_defaults();
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_UNUSED_LO, 16'hFFFF);
    send_cmd(OP_UNUSED_HI, 16'h5A5A);
  endtask

  task automatic test_stepping_commands();
    set_config(16'd1, 16'd5);
    send_cmd(OP_LOAD, 16'd3);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_RELEASE, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_LOAD, 16'hFFFE);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_ZERO, 16'h0000);
    send_cmd(OP_LOAD, 16'h7FFF);
    send_cmd(OP_LOAD, 16'h8000);
    send_cmd(OP_CANCEL, 16'h0000);
    send_cmd(OP_UNUSED_MID, 16'h8001);
  endtask

  task automatic test_zero_settings();
    set_config(16'd0, 16'd0);
    send_cmd(OP_LOAD, 16'd2);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
    send_cmd(OP_TICK, 16'h0000);
  endtask

  task automatic test_modulus_shrink();
    set_config(16'd0, 16'd8);
    send_cmd(OP_ZERO, 16'h0000);
    send_cmd(OP_LOAD, 16'd6);
    repeat (6) send_cmd(OP_TICK, 16'h0000);
    set_config(16'd0, 16'd4);
    send_cmd(OP_LOAD, 16'hFFFF);
    send_cmd(OP_TICK, 16'h0000);
    set_config(16'd0, 16'd3);
    send_cmd(OP_LOAD, 16'd1);
    send_cmd(OP_TICK, 16'h0000);
  endtask

  task automatic test_config_extremes();
    set_config(16'd0, 16'hFFFF);
    send_cmd(OP_ZERO, 16'h0000);
    send_cmd(OP_LOAD, 16'hFFFF);
    send_cmd(OP_TICK, 16'h0000);
    set_config(16'hFFFF, 16'hFFFF);
    send_cmd(OP_LOAD, 16'd1);
    repeat (3) send_cmd(OP_TICK, 16'h0000);
  endtask

  task automatic test_random_motion(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    int unsigned span;
    logic [FIELD_W-1:0] count;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_cmd(OPCODE_W'($urandom_range(0, 7)), FIELD_W'($urandom()));
        sent++;
      end else if (pick < 28) begin
        wait_results_done();
      end else begin
        if ($urandom_range(0, 9) == 0) count = FIELD_W'($urandom());
        else count = FIELD_W'($urandom_range(0, 24) - 12);
        send_cmd(OP_LOAD, count);
        sent++;
        span = 13 * ((cur_period == '0) ? 1 : int'(cur_period));
        run = $urandom_range(1, (span > 200) ? 200 : span);
        while (run != 0 && sent < n_items) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) send_cmd(OP_CANCEL, FIELD_W'($urandom()));
          else if (pick < 4) send_cmd(OP_RELEASE, FIELD_W'($urandom()));
          else if (pick < 6) send_cmd(OP_ZERO, FIELD_W'($urandom()));
          else send_cmd(OP_TICK, FIELD_W'($urandom()));
          sent++;
          run--;
        end
      end
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] modulus;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_STEP_PERIOD;
    cfg_data_i        <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.opcode     <= OP_TICK;
    cmd_if.step_count <= '0;
    cur_period     = STEP_PERIOD_RST;
    cur_modulus    = POS_MODULUS_RST;
    drv_phase      = '0;
    drv_coils      = '0;
    drv_position   = '0;
    drv_steps_left = '0;
    drv_ticks      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_stepping_commands();
    test_zero_settings();
    test_modulus_shrink();
    test_config_extremes();

    for (int unsigned round = 0; round < RANDOM_ROUNDS; round++) begin
      if ($urandom_range(0, 3) == 0) period = FIELD_W'($urandom_range(7, 30));
      else period = FIELD_W'($urandom_range(1, 6));
      case ($urandom_range(0, 2))
        0:       modulus = FIELD_W'($urandom_range(1, 16));
        1:       modulus = FIELD_W'($urandom_range(1, 65535));
        default: modulus = 16'hFFFF;
      endcase
      set_config(period, modulus);
      no_gaps = (round == 2);
      test_random_motion(ROUND_ITEMS);
    end

    wait_results_done();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/shdrv_pkg.sv
rtl/shdrv_cmd_if.sv
rtl/shdrv_res_if.sv
rtl/shdrv_step_unit.sv
rtl/stepper_half_step_driver_core.sv
dv/tb_stepper_half_step_driver_core.sv
